// File: hdl/lzed_pkg.sv
// ============================================================================
// lzed_pkg
// Shared types and constants for the escape-coded LZ77 decoder: the payload
// items of both channels, the item that runs from the front to the back, and
// the status and configuration register codes.
// ============================================================================
`default_nettype none

package lzed_pkg;

    // Default size of the history ring in bytes.
    localparam int HISTORY_DEPTH_DEF = 4096;

    // Entries of the queue between the parser and the history unit.
    localparam int QUEUE_DEPTH = 2;

    // Field widths fixed by the stream format.
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int WINDOW_W = 12;
    localparam int CFG_W    = 12;

    // Configuration register indexes.
    localparam logic CFG_ESCAPE_BYTE  = 1'b0;
    localparam logic CFG_WINDOW_LIMIT = 1'b1;

    // Request kinds on the input channel.
    localparam logic REQ_PUSH    = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_NONE       = 2'd0,
        ST_BYTE       = 2'd1,
        ST_BAD_OFFSET = 2'd2,
        ST_BUSY       = 2'd3
    } t_status;

    // What the history unit does with a queued item.
    typedef enum logic [1:0] {
        OP_PASS    = 2'd0,
        OP_LITERAL = 2'd1,
        OP_COPY    = 2'd2
    } t_op_kind;

    // Input item.
    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] in_byte;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        t_status           status;
        logic [LEN_W-1:0]  copy_left;
    } t_out_item;

    // Classified item handed from the parser to the history unit.
    typedef struct packed {
        t_op_kind          kind;
        logic [BYTE_W-1:0] data;
        t_status           status;
        logic [LEN_W-1:0]  copy_left;
    } t_op;

endpackage

`default_nettype wire

// File: hdl/lz77_escape_decoder_top.sv
// ============================================================================
// lz77_escape_decoder_top
// Escape-coded LZ77 decoder: a token parser, a short queue and a history
// unit with a ring of HISTORY_DEPTH bytes.
//
//   Channel  Direction  Handshake                  Payload
//   input    in         i_in_valid / o_in_stall    i_in_item  (t_in_item)
//   output   out        o_out_valid / i_out_stall  o_out_item (t_out_item)
//   config   in         i_cfg_wr_en                i_cfg_index, i_cfg_wdata
//
// One item is accepted per cycle while the queue is not full; each gives exactly
// one result item, which passes through the queue and the output register
// and leaves the output register when the output side does not stall.
// The rate is set by the single read and single write port of the ring.
// Reset is synchronous and needs no clearing pass: ring entries not yet
// written since reset read as zero through a write-pointer fill mark.
// While a result waits, the two-entry queue takes two more items before the
// input stalls.
// ============================================================================
`default_nettype none

module lz77_escape_decoder_top
    import lzed_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Configuration writes
    input  wire logic             i_cfg_wr_en,
    input  wire logic             i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    // Input channel
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    // Output channel
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item
);

    localparam int PW = $clog2(HISTORY_DEPTH);

    logic          accept;
    logic          q_full;
    t_op           front_op;
    logic [PW-1:0] front_back;
    logic          q_pop;
    logic          q_valid;
    t_op           q_op;
    logic [PW-1:0] q_back;

    assign o_in_stall = q_full;

    // Token parser.
    lzed_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PW            (PW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_accept    (accept),
        .i_full      (q_full),
        .o_op        (front_op),
        .o_back      (front_back)
    );

    // Queue between parser and history unit.
    lzed_queue #(
        .BACK_W (PW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_op    (front_op),
        .i_back  (front_back),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op),
        .o_back  (q_back)
    );

    // History ring and output register.
    lzed_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PW            (PW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head_op    (q_op),
        .i_head_back  (q_back),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .i_out_stall  (i_out_stall)
    );

endmodule

`default_nettype wire

// File: hdl/lzed_front.sv
// ============================================================================
// lzed_front
// Token parser. Holds the configuration registers, walks the escape, length
// and offset bytes, counts down the pending copy and hands one classified
// item per accepted input item to the queue.
// ============================================================================
`default_nettype none

module lzed_front
    import lzed_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int PW            = $clog2(HISTORY_DEPTH)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Configuration writes
    input  wire logic                i_cfg_wr_en,
    input  wire logic                i_cfg_index,
    input  wire logic [CFG_W-1:0]    i_cfg_wdata,
    // Input channel
    input  wire logic                i_in_valid,
    input  wire t_in_item            i_in_item,
    output logic                     o_accept,
    // Queue write side
    input  wire logic                i_full,
    output t_op                      o_op,
    output logic [PW-1:0]            o_back
);

    // Parser phases.
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_LEN_LO  = 6'b000010,
        PH_LEN_HI  = 6'b000100,
        PH_DIST_LO = 6'b001000,
        PH_DIST_HI = 6'b010000,
        PH_COPY    = 6'b100000
    } t_phase;

    // Tables for the offset modulo the ring size, split by offset byte.
    typedef logic [255:0][PW-1:0] t_lo_tbl;
    typedef logic [15:0][PW-1:0]  t_hi_tbl;

    function automatic t_lo_tbl f_lo_tbl();
        t_lo_tbl tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = PW'(i % HISTORY_DEPTH);
        end
        return tbl;
    endfunction

    function automatic t_hi_tbl f_hi_tbl();
        t_hi_tbl tbl;
        for (int i = 0; i < 16; i++) begin
            tbl[i] = PW'((i * 256) % HISTORY_DEPTH);
        end
        return tbl;
    endfunction

    localparam t_lo_tbl LoModTbl = f_lo_tbl();
    localparam t_hi_tbl HiModTbl = f_hi_tbl();

    logic [BYTE_W-1:0]   r_escape;
    logic [WINDOW_W-1:0] r_window;
    t_phase              r_phase, n_phase;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [BYTE_W-1:0]   r_dist_lo, n_dist_lo;
    logic [PW-1:0]       r_back, n_back;

    logic [LEN_W-1:0]    len_m1;
    logic [LEN_W-1:0]    len_full;
    logic [LEN_W-1:0]    dist_full;
    logic                dist_bad;
    logic [PW:0]         back_sum;
    logic [PW-1:0]       back_mod;
    t_op                 op;

    assign o_accept = i_in_valid && !i_full;

    // Offset reduced modulo the ring size; only used when the offset passed.
    assign back_sum = {1'b0, LoModTbl[r_dist_lo]} + {1'b0, HiModTbl[i_in_item.in_byte[3:0]]};
    assign back_mod = (back_sum >= (PW+1)'(HISTORY_DEPTH))
                    ? PW'(back_sum - (PW+1)'(HISTORY_DEPTH))
                    : back_sum[PW-1:0];

    assign len_m1    = r_len - LEN_W'(1);
    assign len_full  = {i_in_item.in_byte, r_len[BYTE_W-1:0]};
    assign dist_full = {i_in_item.in_byte, r_dist_lo};
    assign dist_bad  = (dist_full == '0) || (dist_full > {4'h0, r_window});

    // Classify the item and work out the next parser state.
    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_dist_lo = r_dist_lo;
        n_back    = r_back;
        op        = '{kind: OP_PASS, data: '0, status: ST_NONE, copy_left: '0};
        if (i_in_item.req_type == REQ_ADVANCE) begin
            if (r_phase == PH_COPY) begin
                n_len = len_m1;
                if (len_m1 == '0) begin
                    n_phase = PH_IDLE;
                end
                op.kind      = OP_COPY;
                op.status    = ST_BYTE;
                op.copy_left = len_m1;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_in_item.in_byte == r_escape) begin
                        n_phase = PH_LEN_LO;
                    end else begin
                        op.kind   = OP_LITERAL;
                        op.data   = i_in_item.in_byte;
                        op.status = ST_BYTE;
                    end
                end
                PH_LEN_LO: begin
                    n_len   = {8'h00, i_in_item.in_byte};
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len = len_full;
                    if (len_full == '0) begin
                        n_phase   = PH_IDLE;
                        op.kind   = OP_LITERAL;
                        op.data   = r_escape;
                        op.status = ST_BYTE;
                    end else begin
                        n_phase = PH_DIST_LO;
                    end
                end
                PH_DIST_LO: begin
                    n_dist_lo = i_in_item.in_byte;
                    n_phase   = PH_DIST_HI;
                end
                PH_DIST_HI: begin
                    if (dist_bad) begin
                        n_phase   = PH_IDLE;
                        n_len     = '0;
                        op.status = ST_BAD_OFFSET;
                    end else begin
                        n_phase      = PH_COPY;
                        n_back       = back_mod;
                        op.copy_left = r_len;
                    end
                end
                PH_COPY: begin
                    op.status    = ST_BUSY;
                    op.copy_left = r_len;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    assign o_op   = op;
    assign o_back = r_back;

    // Parser state, advanced on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_len     <= '0;
            r_dist_lo <= '0;
            r_back    <= '0;
        end else if (o_accept) begin
            r_phase   <= n_phase;
            r_len     <= n_len;
            r_dist_lo <= n_dist_lo;
            r_back    <= n_back;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape <= '0;
            r_window <= '1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ESCAPE_BYTE:  r_escape <= i_cfg_wdata[BYTE_W-1:0];
                CFG_WINDOW_LIMIT: r_window <= i_cfg_wdata[WINDOW_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/lzed_queue.sv
// ============================================================================
// lzed_queue
// Short register queue between the parser and the history unit, so that
// each side can stall on its own.
// ============================================================================
`default_nettype none

module lzed_queue
    import lzed_pkg::*;
#(
    parameter int BACK_W = $clog2(HISTORY_DEPTH_DEF)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Write side
    input  wire logic              i_push,
    input  wire t_op               i_op,
    input  wire logic [BACK_W-1:0] i_back,
    output logic                   o_full,
    // Read side
    input  wire logic              i_pop,
    output logic                   o_valid,
    output t_op                    o_op,
    output logic [BACK_W-1:0]      o_back
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op               r_op   [QUEUE_DEPTH];
    logic [BACK_W-1:0] r_back [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_op[r_rd_ptr];
    assign o_back  = r_back[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_op[r_wr_ptr]   <= i_op;
            r_back[r_wr_ptr] <= i_back;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/lzed_back.sv
// ============================================================================
// lzed_back
// History unit. Takes classified items from the queue, reads the history
// ring for copies, writes every emitted byte back to the ring and holds the
// result item in the output register.
// ============================================================================
`default_nettype none

module lzed_back
    import lzed_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int PW            = $clog2(HISTORY_DEPTH)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // Queue read side
    input  wire logic           i_head_valid,
    input  wire t_op            i_head_op,
    input  wire logic [PW-1:0]  i_head_back,
    output logic                o_pop,
    // Output channel
    output logic                o_out_valid,
    output t_out_item           o_out_item,
    input  wire logic           i_out_stall
);

    logic [BYTE_W-1:0] r_hist [HISTORY_DEPTH];

    logic [PW-1:0]     r_wp;
    logic              r_wrapped;
    logic              r_s1_valid;
    t_op               r_s1_op;
    logic [PW-1:0]     r_s1_wp;
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_written;
    logic              r_fwd;
    logic [BYTE_W-1:0] r_fwd_data;

    logic              s1_accept;
    logic              s1_writes;
    logic [BYTE_W-1:0] s1_byte;
    logic              head_writes;
    logic              head_copy;
    logic [PW:0]       diff;
    logic [PW-1:0]     rd_idx;
    logic              rd_written;

    assign s1_accept   = r_s1_valid && !i_out_stall;
    assign o_pop       = i_head_valid && (!r_s1_valid || !i_out_stall);
    assign s1_writes   = (r_s1_op.kind == OP_LITERAL) || (r_s1_op.kind == OP_COPY);
    assign head_copy   = (i_head_op.kind == OP_COPY);
    assign head_writes = (i_head_op.kind == OP_LITERAL) || head_copy;

    // Read index: write pointer minus the offset, wrapped into the ring.
    assign diff   = {1'b0, r_wp} - {1'b0, i_head_back};
    assign rd_idx = diff[PW] ? PW'(diff + (PW+1)'(HISTORY_DEPTH)) : diff[PW-1:0];

    // Entries past the write pointer are unwritten until the first wrap.
    assign rd_written = r_wrapped || (rd_idx < r_wp);

    // Byte of the item in the output register.
    always_comb begin
        case (r_s1_op.kind)
            OP_LITERAL: s1_byte = r_s1_op.data;
            OP_COPY: begin
                if (r_fwd) begin
                    s1_byte = r_fwd_data;
                end else if (r_rd_written) begin
                    s1_byte = r_rd_data;
                end else begin
                    s1_byte = '0;
                end
            end
            default:    s1_byte = '0;
        endcase
    end

    assign o_out_valid          = r_s1_valid;
    assign o_out_item.out_byte  = s1_byte;
    assign o_out_item.status    = r_s1_op.status;
    assign o_out_item.copy_left = r_s1_op.copy_left;

    // History ring: byte written when its result leaves, copy read on pop.
    always_ff @(posedge i_clk) begin
        if (s1_accept && s1_writes) begin
            r_hist[r_s1_wp] <= s1_byte;
        end
        if (o_pop && head_copy) begin
            r_rd_data <= r_hist[rd_idx];
        end
    end

    // Read qualifiers, with forwarding of the byte written at the same edge.
    always_ff @(posedge i_clk) begin
        if (o_pop && head_copy) begin
            r_rd_written <= rd_written;
            r_fwd        <= s1_accept && s1_writes && (rd_idx == r_s1_wp);
            r_fwd_data   <= s1_byte;
        end
    end

    // Output register payload and its ring slot.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_op <= i_head_op;
            r_s1_wp <= r_wp;
        end
    end

    // Output valid, write pointer and wrap flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wp       <= '0;
            r_wrapped  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_accept) begin
                r_s1_valid <= 1'b0;
            end
            if (o_pop && head_writes) begin
                if (r_wp == PW'(HISTORY_DEPTH - 1)) begin
                    r_wp      <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wp <= r_wp + PW'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: verif/lz77_escape_decoder_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// lz77_escape_decoder_top_tb
// Self-checking bench for the escape-coded LZ77 decoder. A queue of stream
// requests feeds a driver. A predictor with its own parser state and history
// ring computes the result of every accepted item. A monitor compares each
// result, field by field, with the oldest prediction. The run covers directed
// corner cases and then random, mostly well-formed token streams under
// several escape and window settings, with random idling on both sides.
// ============================================================================

module lz77_escape_decoder_top_tb;
    import lzed_pkg::*;

    localparam int RING_AW = $clog2(HISTORY_DEPTH_DEF);

    // Parser phases of the predictor.
    typedef enum logic [2:0] {
        TOK_IDLE,
        TOK_LEN_LO,
        TOK_LEN_HI,
        TOK_DIST_LO,
        TOK_DIST_HI,
        TOK_COPY
    } t_tok_phase;

    // Clock, reset and block inputs, all known from time zero.
    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_wr_en  = 1'b0;
    logic             cfg_index  = CFG_ESCAPE_BYTE;
    logic [CFG_W-1:0] cfg_wdata  = '0;
    logic             in_valid   = 1'b0;
    t_in_item         in_item    = '0;
    logic             out_stall  = 1'b0;
    logic             in_stall;
    logic             out_valid;
    t_out_item        out_item;

    // Stream requests waiting to be driven, and predicted results.
    t_in_item  stream_q[$];
    t_out_item predicted_out[$];
    t_out_item result_want;
    int        queued_total = 0;
    int        fail_count   = 0;

    // Idling: one chance in idle_odds per cycle to start a burst; zero means none.
    int unsigned idle_odds = 4;
    int unsigned in_gap    = 0;
    int unsigned stall_gap = 0;

    // Predictor state and configuration copy.
    t_tok_phase         tok_phase = TOK_IDLE;
    logic [LEN_W-1:0]   tok_len   = '0;
    logic [LEN_W-1:0]   tok_dist  = '0;
    logic [BYTE_W-1:0]  hist_ring [HISTORY_DEPTH_DEF];
    logic [RING_AW-1:0] hist_wr   = '0;
    logic [BYTE_W-1:0]  esc_cfg   = 8'h00;
    logic [WINDOW_W-1:0] win_cfg  = 12'd4095;

    lz77_escape_decoder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Every emitted byte goes into the history ring.
    function automatic void append_history(input logic [BYTE_W-1:0] b);
        hist_ring[hist_wr] = b;
        hist_wr = hist_wr + RING_AW'(1);
    endfunction

    // Works out the result of one accepted item and advances the parser state.
    function automatic t_out_item decode_item(input t_in_item it);
        t_out_item          r;
        logic [RING_AW-1:0] idx;
        logic [BYTE_W-1:0]  b;
        r.out_byte  = '0;
        r.status    = ST_NONE;
        r.copy_left = '0;
        b = it.in_byte;
        if (it.req_type == REQ_ADVANCE) begin
            if (tok_phase == TOK_COPY) begin
                idx = hist_wr - tok_dist[RING_AW-1:0];
                r.out_byte = hist_ring[idx];
                append_history(r.out_byte);
                tok_len = tok_len - LEN_W'(1);
                if (tok_len == '0) tok_phase = TOK_IDLE;
                r.status    = ST_BYTE;
                r.copy_left = tok_len;
            end
            return r;
        end
        case (tok_phase)
            TOK_IDLE: begin
                if (b == esc_cfg) begin
                    tok_phase = TOK_LEN_LO;
                end else begin
                    append_history(b);
                    r.out_byte = b;
                    r.status   = ST_BYTE;
                end
            end
            TOK_LEN_LO: begin
                tok_len   = {8'h00, b};
                tok_phase = TOK_LEN_HI;
            end
            TOK_LEN_HI: begin
                tok_len = {b, tok_len[7:0]};
                if (tok_len == '0) begin
                    // A zero length stands for the escape byte itself.
                    tok_phase = TOK_IDLE;
                    append_history(esc_cfg);
                    r.out_byte = esc_cfg;
                    r.status   = ST_BYTE;
                end else begin
                    tok_phase = TOK_DIST_LO;
                end
            end
            TOK_DIST_LO: begin
                tok_dist  = {8'h00, b};
                tok_phase = TOK_DIST_HI;
            end
            TOK_DIST_HI: begin
                tok_dist = {b, tok_dist[7:0]};
                if (tok_dist == '0 || tok_dist > {4'h0, win_cfg}) begin
                    tok_phase = TOK_IDLE;
                    tok_len   = '0;
                    r.status  = ST_BAD_OFFSET;
                end else begin
                    tok_phase   = TOK_COPY;
                    r.copy_left = tok_len;
                end
            end
            TOK_COPY: begin
                // A push during a copy is refused and changes nothing.
                r.status    = ST_BUSY;
                r.copy_left = tok_len;
            end
            default: begin
                tok_phase = TOK_IDLE;
            end
        endcase
        return r;
    endfunction

    // Driver: predicts at acceptance, then loads the next item or idles.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_valid && !in_stall) predicted_out.push_back(decode_item(in_item));
            if (!in_valid || !in_stall) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                    in_gap = $urandom_range(0, 18);
                    in_valid <= 1'b0;
                end else if (stream_q.size() != 0) begin
                    in_item  <= stream_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side stalls in random bursts.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_gap = 0;
        end else if (stall_gap > 0) begin
            stall_gap = stall_gap - 1;
            out_stall <= 1'b1;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_gap = $urandom_range(0, 18);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Reports one mismatching field.
    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endfunction

    // Monitor: each accepted result against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (predicted_out.size() == 0) begin
                fail_count++;
                $display("%0t ns: unexpected result, expected none, actual %p",
                         $time, out_item);
            end else begin
                result_want = predicted_out.pop_front();
                check_field("out_byte", 16'(result_want.out_byte), 16'(out_item.out_byte));
                check_field("status", 16'(result_want.status), 16'(out_item.status));
                check_field("copy_left", result_want.copy_left, out_item.copy_left);
            end
        end
    end

    function automatic void queue_req(input logic req, input logic [BYTE_W-1:0] b);
        t_in_item it;
        it.req_type = req;
        it.in_byte  = b;
        stream_q.push_back(it);
        queued_total++;
    endfunction

    // Queues a full token: escape, length and distance, low bytes first.
    function automatic void queue_token(input logic [15:0] len, input logic [15:0] back_dist);
        queue_req(REQ_PUSH, esc_cfg);
        queue_req(REQ_PUSH, len[7:0]);
        queue_req(REQ_PUSH, len[15:8]);
        queue_req(REQ_PUSH, back_dist[7:0]);
        queue_req(REQ_PUSH, back_dist[15:8]);
    endfunction

    // Random stream: mostly literals and well-formed tokens, some noise.
    task automatic gen_stream(input int count);
        int                start;
        int unsigned       pick;
        int unsigned       lim;
        logic [15:0]       len;
        logic [15:0]       back_dist;
        logic [BYTE_W-1:0] lit;
        start = queued_total;
        while (queued_total - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                lit = 8'($urandom);
                if (lit == esc_cfg) lit = lit ^ 8'h01;
                queue_req(REQ_PUSH, lit);
            end else if (pick < 43) begin
                queue_token(16'h0000, 16'h0000);
                // The distance bytes of a zero-length token are never read.
                repeat (2) void'(stream_q.pop_back());
                queued_total -= 2;
            end else if (pick < 85) begin
                len = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(256, 600)
                                                      : $urandom_range(1, 24));
                if (win_cfg == '0 || $urandom_range(0, 6) == 0) begin
                    back_dist = 16'(($urandom_range(0, 1) == 0) ? 0
                              : $urandom_range(int'(win_cfg) + 1, 65535));
                    queue_token(len, back_dist);
                    if ($urandom_range(0, 1) == 0) queue_req(REQ_ADVANCE, 8'($urandom));
                end else begin
                    lim = (win_cfg < 32) ? win_cfg : 32;
                    back_dist = 16'(($urandom_range(0, 9) < 7) ? $urandom_range(1, lim)
                                                               : $urandom_range(1, win_cfg));
                    queue_token(len, back_dist);
                    repeat (len) begin
                        if ($urandom_range(0, 15) == 0) queue_req(REQ_PUSH, 8'($urandom));
                        queue_req(REQ_ADVANCE, 8'($urandom));
                    end
                end
            end else begin
                // Stray item; a stray push never opens a token.
                lit = 8'($urandom);
                if (lit == esc_cfg) lit = lit ^ 8'h01;
                queue_req(1'($urandom_range(0, 1)), lit);
            end
        end
    endtask

    // Waits until every queued item has been driven and every result has come.
    task automatic wait_drained();
        do begin
            @(negedge clk);
        end while (stream_q.size() != 0 || in_valid || predicted_out.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Brings the parser back to idle so that a new setting starts clean.
    task automatic settle_parser();
        while (tok_phase != TOK_IDLE) begin
            if (tok_phase == TOK_COPY) begin
                repeat (tok_len) queue_req(REQ_ADVANCE, 8'($urandom));
            end else begin
                queue_req(REQ_PUSH, 8'h00);
            end
            wait_drained();
        end
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_ESCAPE_BYTE) esc_cfg = val[BYTE_W-1:0];
        else win_cfg = val[WINDOW_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // One setting: drain, settle the parser, write both registers, then a random stream.
    task automatic run_phase(input logic [7:0] esc, input logic [11:0] win,
                             input int count, input int unsigned odds);
        wait_drained();
        settle_parser();
        write_reg(CFG_ESCAPE_BYTE, {4'($urandom), esc});
        write_reg(CFG_WINDOW_LIMIT, win);
        idle_odds = odds;
        gen_stream(count);
    endtask

    // Stimulus.
    initial begin
        for (int i = 0; i < HISTORY_DEPTH_DEF; i++) hist_ring[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under reset settings: escape 0x00, window 4095.
        queue_req(REQ_ADVANCE, 8'hFF);          // advance with no copy pending
        queue_req(REQ_PUSH, 8'hFF);             // literal at the top of the range
        queue_token(16'h0000, 16'h0000);        // escaped escape byte
        repeat (2) void'(stream_q.pop_back());
        queued_total -= 2;
        queue_token(16'd3, 16'd0);              // distance zero is an error
        queue_token(16'd2, 16'd4095);           // widest window, reads the cleared ring
        queue_req(REQ_ADVANCE, 8'h00);
        queue_req(REQ_PUSH, 8'h55);             // refused while copying
        queue_req(REQ_ADVANCE, 8'h7F);
        queue_req(REQ_ADVANCE, 8'h80);          // copy already done
        queue_req(REQ_PUSH, 8'h41);
        queue_req(REQ_PUSH, 8'h42);
        queue_token(16'd3, 16'd2);              // overlapping copy repeats the pair
        repeat (3) queue_req(REQ_ADVANCE, 8'h01);
        gen_stream(250);

        run_phase(8'hFF, 12'd4095, 280, 12);
        run_phase(8'h1B, 12'd1, 280, 0);
        run_phase(8'h80, 12'd0, 150, 3);        // zero window rejects every distance
        run_phase(8'($urandom), 12'($urandom_range(1, 4095)), 300, 8);
        run_phase(8'h00, 12'd16, 250, 5);

        // Last part without idling: a random tail, then one long copy that
        // walks copy_left down from its top bit and is still pending at the end.
        run_phase(8'h5A, 12'd4095, 0, 0);
        repeat (20) queue_req(REQ_PUSH, 8'($urandom_range(0, 8'h59)));
        gen_stream(140);
        queue_token(16'h8001, 16'd16);
        repeat (40) begin
            if ($urandom_range(0, 7) == 0) queue_req(REQ_PUSH, 8'($urandom));
            queue_req(REQ_ADVANCE, 8'($urandom));
        end
        wait_drained();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
hdl/lzed_pkg.sv
hdl/lzed_front.sv
hdl/lzed_queue.sv
hdl/lzed_back.sv
hdl/lz77_escape_decoder_top.sv
verif/lz77_escape_decoder_top_tb.sv
